// ===== sv/lrupr_pkg.sv =====
// Shared constants for the LRU page replacement block.
package lrupr_pkg;

	// Default build parameters
	localparam int DEF_MAX_FRAMES = 8;
	localparam int DEF_PAGE_BITS  = 16;

	// Configuration register
	localparam int               CFG_W        = 4;
	localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd8;

	// Saturating statistics counters
	localparam int CNT_BITS = 32;

endpackage

// ===== sv/lrupr_cell.sv =====
// One frame cell: tag, valid, recency rank, and one stage of the lookup chain.
module lrupr_cell
	import lrupr_pkg::*;
#(
	parameter  int MAX_FRAMES = DEF_MAX_FRAMES,
	parameter  int PAGE_BITS  = DEF_PAGE_BITS,
	parameter  int CELL_IDX   = 0,
	localparam int SW         = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
	localparam int RW         = SW,
	localparam int NW         = $clog2(MAX_FRAMES + 1),
	localparam int TOK_W      = 3 + 2 * PAGE_BITS + 3 * SW + 2 * RW,
	localparam int UPD_W      = 3 + SW + RW + PAGE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [NW-1:0]    n_act,
	input  logic [TOK_W-1:0] tok_in,
	input  logic [UPD_W-1:0] upd_in,
	output logic [TOK_W-1:0] tok_out
);

	typedef struct packed {
		logic                 vld;
		logic [PAGE_BITS-1:0] page;
		logic                 hit_f;
		logic [SW-1:0]        hit_idx;
		logic [RW-1:0]        hit_rank;
		logic                 emp_f;
		logic [SW-1:0]        emp_idx;
		logic [SW-1:0]        lru_idx;
		logic [RW-1:0]        lru_rank;
		logic [PAGE_BITS-1:0] lru_tag;
	} tok_t;

	typedef struct packed {
		logic                 en;
		logic [SW-1:0]        slot;
		logic [RW-1:0]        limit;
		logic                 age_all;
		logic                 write_tag;
		logic [PAGE_BITS-1:0] page;
	} upd_t;

	localparam logic [SW-1:0] MY_SLOT  = SW'(CELL_IDX);
	localparam logic [RW-1:0] RANK_MAX = RW'(MAX_FRAMES - 1);
	localparam bit            IS_FIRST = (CELL_IDX == 0);

	tok_t                 tin;
	tok_t                 tnxt;
	tok_t                 tok_q;
	upd_t                 upd;
	logic                 active;
	logic                 valid_q;
	logic [RW-1:0]        rank_q;
	logic [PAGE_BITS-1:0] tag_q;

	assign tin     = tok_t'(tok_in);
	assign upd     = upd_t'(upd_in);
	assign tok_out = TOK_W'(tok_q);
	assign active  = (32'(n_act) > CELL_IDX);

	// Fold this frame into the passing lookup transaction
	always_comb begin
		tnxt = tin;
		if (tin.vld && active) begin
			if (!tin.hit_f && valid_q && (tag_q == tin.page)) begin
				tnxt.hit_f    = 1'b1;
				tnxt.hit_idx  = MY_SLOT;
				tnxt.hit_rank = rank_q;
			end
			if (!tin.emp_f && !valid_q) begin
				tnxt.emp_f   = 1'b1;
				tnxt.emp_idx = MY_SLOT;
			end
			if (IS_FIRST || (rank_q > tin.lru_rank)) begin
				tnxt.lru_idx  = MY_SLOT;
				tnxt.lru_rank = rank_q;
				tnxt.lru_tag  = tag_q;
			end
		end
	end

	// Hand the transaction to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tnxt;
		end
	end

	// Apply the broadcast update: refresh the chosen frame, age younger ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.en) begin
			if (upd.slot == MY_SLOT) begin
				rank_q <= '0;
				if (upd.write_tag) begin
					valid_q <= 1'b1;
				end
			end else if (valid_q && (upd.age_all || (rank_q < upd.limit)) &&
			             (rank_q < RANK_MAX)) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	// Load the new page tag
	always_ff @(posedge clk) begin
		if (upd.en && (upd.slot == MY_SLOT) && upd.write_tag) begin
			tag_q <= upd.page;
		end
	end

endmodule

// ===== sv/lrupr_ctl.sv =====
// Sequencer: handshakes, configuration, replacement decision and statistics.
module lrupr_ctl
	import lrupr_pkg::*;
#(
	parameter  int MAX_FRAMES = DEF_MAX_FRAMES,
	parameter  int PAGE_BITS  = DEF_PAGE_BITS,
	localparam int SW         = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
	localparam int RW         = SW,
	localparam int NW         = $clog2(MAX_FRAMES + 1),
	localparam int TOK_W      = 3 + 2 * PAGE_BITS + 3 * SW + 2 * RW,
	localparam int UPD_W      = 3 + SW + RW + PAGE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [SW-1:0]        frame_slot,
	output logic                 evicted_valid,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic [CNT_BITS-1:0]  hit_count,
	output logic [CNT_BITS-1:0]  miss_count,
	output logic [NW-1:0]        n_act,
	output logic [TOK_W-1:0]     tok_start,
	input  logic [TOK_W-1:0]     tok_tail,
	output logic [UPD_W-1:0]     upd_out
);

	typedef struct packed {
		logic                 vld;
		logic [PAGE_BITS-1:0] page;
		logic                 hit_f;
		logic [SW-1:0]        hit_idx;
		logic [RW-1:0]        hit_rank;
		logic                 emp_f;
		logic [SW-1:0]        emp_idx;
		logic [SW-1:0]        lru_idx;
		logic [RW-1:0]        lru_rank;
		logic [PAGE_BITS-1:0] lru_tag;
	} tok_t;

	typedef struct packed {
		logic                 en;
		logic [SW-1:0]        slot;
		logic [RW-1:0]        limit;
		logic                 age_all;
		logic                 write_tag;
		logic [PAGE_BITS-1:0] page;
	} upd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     cfg_q;
	tok_t                 start_q;
	tok_t                 tail;
	upd_t                 upd_q;
	upd_t                 upd_d;
	logic [CNT_BITS-1:0]  hits_q;
	logic [CNT_BITS-1:0]  misses_q;
	logic [CNT_BITS-1:0]  hits_d;
	logic [CNT_BITS-1:0]  misses_d;
	logic                 res_hit_q;
	logic [SW-1:0]        res_slot_q;
	logic                 res_ev_q;
	logic [PAGE_BITS-1:0] res_ev_page_q;
	logic                 res_ev_d;
	logic [PAGE_BITS-1:0] res_ev_page_d;
	logic                 out_valid_q;
	logic                 hit_q;
	logic [SW-1:0]        slot_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;
	logic [CNT_BITS-1:0]  hit_cnt_q;
	logic [CNT_BITS-1:0]  miss_cnt_q;

	assign tail          = tok_t'(tok_tail);
	assign tok_start     = TOK_W'(start_q);
	assign upd_out       = UPD_W'(upd_q);
	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_slot    = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign hit_count     = hit_cnt_q;
	assign miss_count    = miss_cnt_q;

	// Clamp the frame count to one through MAX_FRAMES
	always_comb begin
		if (cfg_q == '0) begin
			n_act = NW'(1);
		end else if (32'(cfg_q) > MAX_FRAMES) begin
			n_act = NW'(MAX_FRAMES);
		end else begin
			n_act = NW'(cfg_q);
		end
	end

	// Pick the frame to refresh from the finished lookup
	always_comb begin
		upd_d         = '0;
		upd_d.en      = 1'b1;
		upd_d.page    = tail.page;
		res_ev_d      = 1'b0;
		res_ev_page_d = '0;
		hits_d        = hits_q;
		misses_d      = misses_q;
		if (tail.hit_f) begin
			upd_d.slot  = tail.hit_idx;
			upd_d.limit = tail.hit_rank;
			hits_d      = (hits_q == '1) ? hits_q : hits_q + 1'b1;
		end else begin
			misses_d        = (misses_q == '1) ? misses_q : misses_q + 1'b1;
			upd_d.write_tag = 1'b1;
			if (tail.emp_f) begin
				upd_d.slot    = tail.emp_idx;
				upd_d.age_all = 1'b1;
			end else begin
				upd_d.slot    = tail.lru_idx;
				upd_d.limit   = tail.lru_rank;
				res_ev_d      = 1'b1;
				res_ev_page_d = tail.lru_tag;
			end
		end
	end

	// Sequence one transaction: launch, wait for the chain, update, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cfg_q         <= FRAMES_RESET;
			start_q       <= '0;
			upd_q         <= '0;
			hits_q        <= '0;
			misses_q      <= '0;
			res_hit_q     <= 1'b0;
			res_slot_q    <= '0;
			res_ev_q      <= 1'b0;
			res_ev_page_q <= '0;
			out_valid_q   <= 1'b0;
			hit_q         <= 1'b0;
			slot_q        <= '0;
			ev_valid_q    <= 1'b0;
			ev_page_q     <= '0;
			hit_cnt_q     <= '0;
			miss_cnt_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			start_q.vld <= 1'b0;
			upd_q.en    <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						start_q.vld  <= 1'b1;
						start_q.page <= page_number;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tail.vld) begin
						upd_q         <= upd_d;
						hits_q        <= hits_d;
						misses_q      <= misses_d;
						res_hit_q     <= tail.hit_f;
						res_slot_q    <= upd_d.slot;
						res_ev_q      <= res_ev_d;
						res_ev_page_q <= res_ev_page_d;
						state_q       <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						hit_q       <= res_hit_q;
						slot_q      <= res_slot_q;
						ev_valid_q  <= res_ev_q;
						ev_page_q   <= res_ev_page_q;
						hit_cnt_q   <= hits_q;
						miss_cnt_q  <= misses_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/lru_page_replacement.sv =====
// Top level: fully associative LRU page replacement over a chain of frame cells.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   input    | in_valid / in_ready  | page_number
//   output   | out_valid / out_ready| hit, frame_slot, evicted_valid, evicted_page,
//            |                      | hit_count, miss_count
//   config   | cfg_wr_en            | cfg_wr_data (frames in use)
//
// Each accepted reference becomes a lookup transaction that walks the cell chain one
// frame per cycle; the controller then registers its decision and broadcasts the
// rank and tag update to every cell before the next reference is accepted.
// A finished result waits in the output register; the next reference is accepted
// while it waits, and only a result that finds the register still full stalls.
// Reset (arst_n low) empties all frames, zeroes ranks and counters, and sets the
// frame count to 8.
module lru_page_replacement
	import lrupr_pkg::*;
#(
	parameter  int MAX_FRAMES = DEF_MAX_FRAMES,
	parameter  int PAGE_BITS  = DEF_PAGE_BITS,
	localparam int SW         = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
	localparam int RW         = SW,
	localparam int NW         = $clog2(MAX_FRAMES + 1),
	localparam int TOK_W      = 3 + 2 * PAGE_BITS + 3 * SW + 2 * RW,
	localparam int UPD_W      = 3 + SW + RW + PAGE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [SW-1:0]        frame_slot,
	output logic                 evicted_valid,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic [CNT_BITS-1:0]  hit_count,
	output logic [CNT_BITS-1:0]  miss_count
);

	logic [TOK_W-1:0] tok_chain [MAX_FRAMES+1];
	logic [UPD_W-1:0] upd;
	logic [NW-1:0]    n_act;

	lrupr_ctl #(
		.MAX_FRAMES(MAX_FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_ctl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.frame_slot   (frame_slot),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.hit_count    (hit_count),
		.miss_count   (miss_count),
		.n_act        (n_act),
		.tok_start    (tok_chain[0]),
		.tok_tail     (tok_chain[MAX_FRAMES]),
		.upd_out      (upd)
	);

	// Build the frame chain
	for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
		lrupr_cell #(
			.MAX_FRAMES(MAX_FRAMES),
			.PAGE_BITS (PAGE_BITS),
			.CELL_IDX  (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.n_act  (n_act),
			.tok_in (tok_chain[g]),
			.upd_in (upd),
			.tok_out(tok_chain[g+1])
		);
	end

endmodule

// ===== sv/lrupr_checker.sv =====
// Port-level checks for the LRU page replacement block, bound to the top level.
module lrupr_checker
	import lrupr_pkg::*;
#(
	parameter  int MAX_FRAMES = DEF_MAX_FRAMES,
	parameter  int PAGE_BITS  = DEF_PAGE_BITS,
	localparam int SW         = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 hit,
	input logic [SW-1:0]        frame_slot,
	input logic                 evicted_valid,
	input logic [PAGE_BITS-1:0] evicted_page,
	input logic [CNT_BITS-1:0]  hit_count,
	input logic [CNT_BITS-1:0]  miss_count
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_slot) &&
		$stable(hit) && $stable(evicted_page) && $stable(hit_count))
		else $error("stalled result changed");

	// Accept one reference at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second reference accepted while one is in flight");

	// A hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evicted_valid)
		else $error("eviction reported on a hit");

	// No eviction reports page zero
	a_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted_valid |-> evicted_page == '0)
		else $error("evicted page nonzero without eviction");

	// A new result that moves the hit counter is a hit and leaves the miss counter unchanged
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid && !$stable(hit_count) |->
		!$stable(hit_count) && $stable(miss_count) && hit)
		else $error("hit counter moved without a hit");

endmodule

bind lru_page_replacement lrupr_checker #(
	.MAX_FRAMES(MAX_FRAMES),
	.PAGE_BITS (PAGE_BITS)
) u_lrupr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.hit          (hit),
	.frame_slot   (frame_slot),
	.evicted_valid(evicted_valid),
	.evicted_page (evicted_page),
	.hit_count    (hit_count),
	.miss_count   (miss_count)
);

// ===== bench/testbench.sv =====
// Self-checking bench for the LRU page replacement block: lookup, fill, eviction and frame count.
`timescale 1ns / 100ps

module testbench;
	import lrupr_pkg::*;

	localparam int FRAMES     = DEF_MAX_FRAMES;
	localparam int PG_W       = DEF_PAGE_BITS;
	localparam int SLOT_W     = $clog2(FRAMES);
	localparam int STALL_MAX  = 4000;
	localparam int DRAIN_WAIT = 4 * (FRAMES + 3);
	localparam int POOL_SIZE  = 12;

	typedef struct packed {
		logic                hit;
		logic [SLOT_W-1:0]   frame_slot;
		logic                evicted_valid;
		logic [PG_W-1:0]     evicted_page;
		logic [CNT_BITS-1:0] hit_count;
		logic [CNT_BITS-1:0] miss_count;
	} page_outcome_t;

	// Mirror of the frame table; predicts the outcome of each page reference
	class lru_frame_tracker;
		logic [PG_W-1:0]     frame_page [FRAMES];
		bit                  frame_used [FRAMES];
		bit [2:0]            frame_age [FRAMES];
		logic [CNT_BITS-1:0] hits;
		logic [CNT_BITS-1:0] misses;
		logic [CFG_W-1:0]    frames_cfg;
		page_outcome_t       outcomes_due [$];
		int                  mismatches;

		function new();
			for (int i = 0; i < FRAMES; i++) begin
				frame_page[i] = '0;
				frame_used[i] = 0;
				frame_age[i]  = '0;
			end
			hits       = '0;
			misses     = '0;
			frames_cfg = FRAMES_RESET;
			mismatches = 0;
		endfunction

		function void set_frames(logic [CFG_W-1:0] v);
			frames_cfg = v;
		endfunction

		// Clamp the register: zero acts as one, above the table size acts as full
		function int active_frames();
			if (frames_cfg == 0)
				return 1;
			if (frames_cfg > FRAMES)
				return FRAMES;
			return frames_cfg;
		endfunction

		// Promote frame f to most recent; age valid frames younger than limit
		function void promote(int f, int limit);
			for (int i = 0; i < FRAMES; i++) begin
				if (i != f && frame_used[i] && frame_age[i] < limit && frame_age[i] < FRAMES - 1)
					frame_age[i]++;
			end
			frame_age[f] = '0;
		endfunction

		function void note_reference(logic [PG_W-1:0] pg);
			int            n;
			int            slot;
			bit            found;
			bit            empty;
			page_outcome_t r;
			n     = active_frames();
			slot  = 0;
			found = 0;
			empty = 0;
			r     = '0;
			// Search the participating frames, lowest match wins
			for (int i = 0; i < n; i++) begin
				if (!found && frame_used[i] && frame_page[i] == pg) begin
					slot  = i;
					found = 1;
				end
			end
			if (found) begin
				if (hits != '1)
					hits++;
				promote(slot, frame_age[slot]);
			end else begin
				if (misses != '1)
					misses++;
				for (int i = 0; i < n; i++) begin
					if (!empty && !frame_used[i]) begin
						slot  = i;
						empty = 1;
					end
				end
				if (empty) begin
					frame_used[slot] = 1;
					frame_page[slot] = pg;
					promote(slot, FRAMES);
				end else begin
					// Replace the oldest participating frame, lowest index on a tie
					slot = 0;
					for (int i = 1; i < n; i++) begin
						if (frame_age[i] > frame_age[slot])
							slot = i;
					end
					r.evicted_valid  = 1;
					r.evicted_page   = frame_page[slot];
					frame_page[slot] = pg;
					promote(slot, frame_age[slot]);
				end
			end
			r.hit        = found;
			r.frame_slot = slot[SLOT_W-1:0];
			r.hit_count  = hits;
			r.miss_count = misses;
			outcomes_due.push_back(r);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		function void compare(string field, longint unsigned want, longint unsigned got);
			if (want != got)
				flag($sformatf("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, field, want, got));
		endfunction

		function void check_result(page_outcome_t got);
			page_outcome_t want;
			if (outcomes_due.size() == 0) begin
				flag($sformatf("%0t: result with no reference outstanding, actual %p", $time, got));
				return;
			end
			want = outcomes_due.pop_front();
			compare("hit", want.hit, got.hit);
			compare("frame_slot", want.frame_slot, got.frame_slot);
			compare("evicted_valid", want.evicted_valid, got.evicted_valid);
			compare("evicted_page", want.evicted_page, got.evicted_page);
			compare("hit_count", want.hit_count, got.hit_count);
			compare("miss_count", want.miss_count, got.miss_count);
		endfunction

		function int outstanding();
			return outcomes_due.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CFG_W-1:0]    cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	logic [PG_W-1:0]     page_number;
	logic                out_valid;
	logic                out_ready;
	logic                hit;
	logic [SLOT_W-1:0]   frame_slot;
	logic                evicted_valid;
	logic [PG_W-1:0]     evicted_page;
	logic [CNT_BITS-1:0] hit_count;
	logic [CNT_BITS-1:0] miss_count;

	lru_frame_tracker tracker;
	int               send_idle_pct;
	int               recv_idle_pct;
	logic [PG_W-1:0]  page_pool [POOL_SIZE];

	lru_page_replacement dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.frame_slot   (frame_slot),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.hit_count    (hit_count),
		.miss_count   (miss_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Set sender and receiver idle rates: sender light first, then receiver light, then none
	task automatic set_idle_mode(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 25;
				recv_idle_pct = 79;
			end
			1: begin
				send_idle_pct = 79;
				recv_idle_pct = 25;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Drive one page reference and hold it until the block accepts it
	task automatic send_page(input logic [PG_W-1:0] pg);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid    <= 1'b1;
		page_number <= pg;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.note_reference(pg);
	endtask

	// Drain outstanding results, then write the frame count while the block is idle
	task automatic write_frames(input logic [CFG_W-1:0] v);
		while (tracker.outstanding() != 0)
			@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_frames(v);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] frames, input logic [PG_W-1:0] pages [$]);
		write_frames(frames);
		foreach (pages[i])
			send_page(pages[i]);
		in_valid <= 1'b0;
	endtask

	// Mostly reuse a small working set near the frame count; sometimes a fresh page
	function automatic logic [PG_W-1:0] draw_page(input int active);
		int              pick;
		logic [PG_W-1:0] pg;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return page_pool[$urandom_range(0, active + 1)];
		if (pick < 85)
			return page_pool[$urandom_range(0, POOL_SIZE - 1)];
		pg = PG_W'($urandom_range(0, 16'hFFFF));
		if ($urandom_range(0, 3) == 0)
			page_pool[$urandom_range(0, POOL_SIZE - 1)] = pg;
		return pg;
	endfunction

	// Accept results at random and check each against the oldest prediction
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				tracker.check_result('{hit, frame_slot, evicted_valid, evicted_page,
					hit_count, miss_count});
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// End the run when no transaction moves for too long
	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_MAX) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall = 0;
			else
				stall++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] rand_frames [12];
		logic [PG_W-1:0]  pages [$];
		tracker = new();
		rand_frames = '{4'd0, 4'd4, 4'd15, 4'd1, 4'd8, 4'd3, 4'd12, 4'd2, 4'd6, 4'd5,
			4'd7, 4'd8};
		foreach (page_pool[i])
			page_pool[i] = PG_W'($urandom_range(0, 16'hFFFF));
		set_idle_mode(0);
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		page_number <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill all frames, hit, then evict the oldest
		pages = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h5555, 16'hAAAA,
			16'h1234, 16'h4321, 16'h0002, 16'h0000, 16'hAAAA, 16'h7FFF};
		run_phase(4'd8, pages);
		// Shrink the range: resident pages outside it miss and get duplicated inside
		pages = '{16'h1234, 16'h5555, 16'h0000};
		run_phase(4'd2, pages);
		// Grow it back: duplicates resolve to the lowest frame
		pages = '{16'h1234, 16'h5555, 16'hFFFF};
		run_phase(4'd8, pages);

		// Random phases over several frame counts, stepping through the idle modes
		foreach (rand_frames[p]) begin
			set_idle_mode(p * 3 / 12);
			tracker.set_frames(tracker.frames_cfg);
			pages.delete();
			write_frames(rand_frames[p]);
			repeat (168)
				pages.push_back(draw_page(tracker.active_frames()));
			foreach (pages[i])
				send_page(pages[i]);
			in_valid <= 1'b0;
		end

		// Drain, then allow stray results to show up
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
